>>> rtl/i2c_master_write_read_sequencer_defines.svh
// Assertion macros for the I2C write-then-read sequencer RTL.
`ifndef I2C_MASTER_WRITE_READ_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_WRITE_READ_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CWR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/i2cwr_pkg.sv
// Types and constants of the I2C write-then-read sequencer.
package i2cwr_pkg;

  localparam int unsigned COUNT_MAX_DEF = 255;
  localparam logic [7:0]  READ_BIT      = 8'h01;

  typedef enum logic [3:0] {
    OP_BEGIN    = 4'd0,
    OP_START    = 4'd1,
    OP_RSTART   = 4'd2,
    OP_ADDRW_ACK = 4'd3,
    OP_DATA_ACK = 4'd4,
    OP_ADDRR_ACK = 4'd5,
    OP_RX_ACK   = 4'd6,
    OP_RX_NACK  = 4'd7,
    OP_OTHER    = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    CMD_SEND    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_NONE    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SLAVE_ADDRESS = 2'd0,
    REG_SEND_COUNT    = 2'd1,
    REG_RECEIVE_COUNT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] bus_byte;
    logic       recv_valid;
    logic [7:0] recv_byte;
    logic       done_res;
    logic       failed;
    logic [7:0] error_status;
  } res_t;

endpackage

>>> rtl/i2cwr_core.sv
// Configuration registers, transfer counters and the per-event decision logic.
module i2cwr_core
  import i2cwr_pkg::*;
#(
  parameter int unsigned COUNT_MAX = COUNT_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       ev_accept,
  input  logic [3:0] ev_operation,
  input  logic [7:0] ev_status_code,
  input  logic [7:0] ev_tx_byte,
  input  logic [7:0] ev_rx_byte,
  output res_t       res
);

  localparam int unsigned CW = $clog2(COUNT_MAX + 1);

  logic [6:0]    slave_address_r;
  logic [7:0]    send_count_r;
  logic [7:0]    receive_count_r;
  logic [CW-1:0] send_left_r, send_left_nxt;
  logic [CW-1:0] read_left_r, read_left_nxt;
  logic          active_r, active_nxt;
  logic [7:0]    addr_byte;
  logic [CW-1:0] read_dec;

  function automatic logic [CW-1:0] clamp_count(input logic [7:0] v);
    logic [16:0] wide;
    wide = {9'd0, v};
    if (wide > 17'(COUNT_MAX)) begin
      return CW'(COUNT_MAX);
    end
    return CW'(v);
  endfunction

  assign addr_byte = {slave_address_r, 1'b0};
  // The read counter saturates at zero rather than wrapping.
  assign read_dec  = (read_left_r != '0) ? read_left_r - CW'(1) : read_left_r;

  always_comb begin
    res           = '0;
    res.command   = CMD_NONE;
    send_left_nxt = send_left_r;
    read_left_nxt = read_left_r;
    active_nxt    = active_r;
    if (ev_operation == OP_BEGIN) begin
      send_left_nxt = clamp_count(send_count_r);
      read_left_nxt = clamp_count(receive_count_r);
      active_nxt    = 1'b1;
      res.command   = CMD_START;
    end else if (active_r) begin
      unique case (ev_operation)
        OP_START: begin
          res.command  = CMD_SEND;
          res.bus_byte = addr_byte;
        end
        OP_RSTART: begin
          res.command  = CMD_SEND;
          res.bus_byte = addr_byte | READ_BIT;
        end
        OP_ADDRW_ACK, OP_DATA_ACK: begin
          if (send_left_r != '0) begin
            res.command   = CMD_SEND;
            res.bus_byte  = ev_tx_byte;
            send_left_nxt = send_left_r - CW'(1);
          end else if (read_left_r != '0) begin
            res.command = CMD_START;
          end else begin
            res.command  = CMD_STOP;
            res.done_res = 1'b1;
            active_nxt   = 1'b0;
          end
        end
        OP_ADDRR_ACK: begin
          res.command = (read_left_r > CW'(1)) ? CMD_RX_ACK : CMD_RX_NACK;
        end
        OP_RX_ACK: begin
          res.recv_valid = 1'b1;
          res.recv_byte  = ev_rx_byte;
          read_left_nxt  = read_dec;
          res.command    = (read_dec > CW'(1)) ? CMD_RX_ACK : CMD_RX_NACK;
        end
        OP_RX_NACK: begin
          res.recv_valid = 1'b1;
          res.recv_byte  = ev_rx_byte;
          res.command    = CMD_STOP;
          res.done_res   = 1'b1;
          active_nxt     = 1'b0;
        end
        default: begin
          // Any status the sequence does not expect aborts the transfer.
          res.command      = CMD_STOP;
          res.done_res     = 1'b1;
          res.failed       = 1'b1;
          res.error_status = ev_status_code;
          active_nxt       = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= '0;
      send_count_r    <= '0;
      receive_count_r <= '0;
      send_left_r     <= '0;
      read_left_r     <= '0;
      active_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLAVE_ADDRESS: slave_address_r <= cfg_data[6:0];
          REG_SEND_COUNT:    send_count_r    <= cfg_data;
          REG_RECEIVE_COUNT: receive_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (ev_accept) begin
        send_left_r <= send_left_nxt;
        read_left_r <= read_left_nxt;
        active_r    <= active_nxt;
      end
    end
  end

endmodule

>>> rtl/i2cwr_out_skid.sv
// Result register with a skid stage so the input stall is fully registered.
module i2cwr_out_skid
  import i2cwr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r;
  res_t skid_data_r;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      // The skid word is older than any new word, so it goes out first.
      out_valid_nxt  = skid_valid_r || push;
      skid_valid_nxt = skid_valid_r && push;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
      if (push) begin
        skid_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/i2c_master_write_read_sequencer.sv
// Top level of the I2C master write-then-read transaction sequencer.
//
// Each input word is one decoded bus status event (in_operation plus the raw
// status and the data bytes); each accepted word yields exactly one result
// word naming the next bus command, the byte to shift out, a received byte
// and the done/failed flags. A begin event loads the byte counters from the
// send_count and receive_count registers and asks for a START.
// Configuration is written through cfg_valid/cfg_ready with cfg_index
// 0 = slave address, 1 = send count, 2 = receive count; cfg_ready is always
// high. Write it only while no transfer words are in flight.
// An accepted word is registered in the result register, or in the skid stage
// behind it if out_stall holds the result register. Throughput is one word
// per cycle while in_stall is low, set by the single decision stage and its
// result register. The skid stage lets one more word in while out_stall
// holds; in_stall rises only when both are occupied, and it comes straight from a flop.
// Synchronous reset (rst_n low) clears the registers, the counters and the
// active flag and empties the output stages.
`include "i2c_master_write_read_sequencer_defines.svh"

module i2c_master_write_read_sequencer
  import i2cwr_pkg::*;
#(
  parameter int unsigned COUNT_MAX = COUNT_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_operation,
  input  logic [7:0] in_status_code,
  input  logic [7:0] in_tx_byte,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_command,
  output logic [7:0] out_bus_byte,
  output logic       out_recv_valid,
  output logic [7:0] out_recv_byte,
  output logic       out_done_res,
  output logic       out_failed,
  output logic [7:0] out_error_status
);

  logic in_accept;
  res_t res;
  res_t out_data;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  i2cwr_core #(
    .COUNT_MAX(COUNT_MAX)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ev_accept     (in_accept),
    .ev_operation  (in_operation),
    .ev_status_code(in_status_code),
    .ev_tx_byte    (in_tx_byte),
    .ev_rx_byte    (in_rx_byte),
    .res           (res)
  );

  i2cwr_out_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_data(res),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign out_command      = out_data.command;
  assign out_bus_byte     = out_data.bus_byte;
  assign out_recv_valid   = out_data.recv_valid;
  assign out_recv_byte    = out_data.recv_byte;
  assign out_done_res     = out_data.done_res;
  assign out_failed       = out_data.failed;
  assign out_error_status = out_data.error_status;

  `I2CWR_ASSERT_NOW(a_stall_needs_output, clk, rst_n, in_stall, out_valid,
    "input stalled while the result register is empty")
  `I2CWR_ASSERT_NOW(a_fail_is_stop, clk, rst_n, out_valid && out_failed,
    out_done_res && out_command == CMD_STOP, "failure without a final STOP")
  `I2CWR_ASSERT_NOW(a_recv_cmd, clk, rst_n, out_valid && out_recv_valid,
    out_command == CMD_RX_ACK || out_command == CMD_RX_NACK || out_command == CMD_STOP,
    "received byte paired with a non-receive command")
  `I2CWR_ASSERT_NEXT(a_accept_shows, clk, rst_n, in_valid && !in_stall && !out_valid,
    out_valid, "accepted word did not reach the result register")

endmodule

>>> verif/tb_i2c_master_write_read_sequencer.sv
// Self-checking testbench for the I2C write-then-read transaction sequencer.
module tb_i2c_master_write_read_sequencer;
  import i2cwr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  // Status codes past the named ones; the block treats all of them as unhandled.
  localparam logic [3:0] OP_UNKNOWN_MID  = 4'd12;
  localparam logic [3:0] OP_UNKNOWN_LAST = 4'd15;

  // Tracks the sequencer's transaction state and holds the commands it must issue.
  class command_board;
    res_t        pending_cmds[$];
    int          mismatches;
    int          results_seen;
    int          transfers_ended;
    logic [6:0]  slave_addr;
    logic [7:0]  send_total;
    logic [7:0]  read_total;
    logic [7:0]  send_left;
    logic [7:0]  read_left;
    bit          active;

    function new();
      mismatches      = 0;
      results_seen    = 0;
      transfers_ended = 0;
      slave_addr      = '0;
      send_total      = '0;
      read_total      = '0;
      send_left       = '0;
      read_left       = '0;
      active          = 1'b0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [7:0] data);
      case (idx)
        REG_SLAVE_ADDRESS: slave_addr = data[6:0];
        REG_SEND_COUNT:    send_total = data;
        REG_RECEIVE_COUNT: read_total = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] clamp_count(logic [7:0] v);
      return (32'(v) > COUNT_MAX_DEF) ? 8'(COUNT_MAX_DEF) : v;
    endfunction

    function res_t predict_next_command(logic [3:0] op, logic [7:0] status,
                                        logic [7:0] tx, logic [7:0] rx);
      res_t r;
      r = '0;
      r.command = CMD_NONE;
      if (op == OP_BEGIN) begin
        send_left = clamp_count(send_total);
        read_left = clamp_count(read_total);
        active    = 1'b1;
        r.command = CMD_START;
      end else if (active) begin
        case (op)
          OP_START: begin
            r.command  = CMD_SEND;
            r.bus_byte = {slave_addr, 1'b0};
          end
          OP_RSTART: begin
            r.command  = CMD_SEND;
            r.bus_byte = {slave_addr, 1'b0} | READ_BIT;
          end
          OP_ADDRW_ACK, OP_DATA_ACK: begin
            if (send_left != 8'd0) begin
              r.command  = CMD_SEND;
              r.bus_byte = tx;
              send_left  = send_left - 8'd1;
            end else if (read_left != 8'd0) begin
              r.command = CMD_START;
            end else begin
              r.command  = CMD_STOP;
              r.done_res = 1'b1;
              active     = 1'b0;
            end
          end
          OP_ADDRR_ACK: r.command = (read_left > 8'd1) ? CMD_RX_ACK : CMD_RX_NACK;
          OP_RX_ACK: begin
            r.recv_valid = 1'b1;
            r.recv_byte  = rx;
            // The read counter stops at zero instead of wrapping.
            if (read_left != 8'd0) read_left = read_left - 8'd1;
            r.command = (read_left > 8'd1) ? CMD_RX_ACK : CMD_RX_NACK;
          end
          OP_RX_NACK: begin
            r.recv_valid = 1'b1;
            r.recv_byte  = rx;
            r.command    = CMD_STOP;
            r.done_res   = 1'b1;
            active       = 1'b0;
          end
          default: begin
            r.command      = CMD_STOP;
            r.done_res     = 1'b1;
            r.failed       = 1'b1;
            r.error_status = status;
            active         = 1'b0;
          end
        endcase
      end
      if (r.done_res) transfers_ended++;
      pending_cmds.push_back(r);
      return r;
    endfunction

    function void check_command(res_t got);
      res_t want;
      results_seen++;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: command word cmd=%0d arrived with nothing expected", got.command);
        return;
      end
      want = pending_cmds.pop_front();
      if (got.command !== want.command || got.bus_byte !== want.bus_byte ||
          got.recv_valid !== want.recv_valid || got.recv_byte !== want.recv_byte ||
          got.done_res !== want.done_res || got.failed !== want.failed ||
          got.error_status !== want.error_status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: word %0d expected cmd=%0d bus=%h rv=%b rb=%h done=%b fail=%b err=%h",
                   results_seen, want.command, want.bus_byte, want.recv_valid,
                   want.recv_byte, want.done_res, want.failed, want.error_status);
          $display("       got      cmd=%0d bus=%h rv=%b rb=%h done=%b fail=%b err=%h",
                   got.command, got.bus_byte, got.recv_valid, got.recv_byte,
                   got.done_res, got.failed, got.error_status);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index      = '0;
  logic [7:0] cfg_data       = '0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [3:0] in_operation   = '0;
  logic [7:0] in_status_code = '0;
  logic [7:0] in_tx_byte     = '0;
  logic [7:0] in_rx_byte     = '0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [2:0] out_command;
  logic [7:0] out_bus_byte;
  logic       out_recv_valid;
  logic [7:0] out_recv_byte;
  logic       out_done_res;
  logic       out_failed;
  logic [7:0] out_error_status;

  command_board board = new();
  res_t         out_word;
  int           items_sent  = 0;
  int           cycle_count = 0;

  i2c_master_write_read_sequencer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_status_code   (in_status_code),
    .in_tx_byte       (in_tx_byte),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_bus_byte     (out_bus_byte),
    .out_recv_valid   (out_recv_valid),
    .out_recv_byte    (out_recv_byte),
    .out_done_res     (out_done_res),
    .out_failed       (out_failed),
    .out_error_status (out_error_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The idle mix moves through three stages as the run progresses.
  function automatic int sender_idle_pct();
    if (items_sent < ITEM_TARGET / 3) return 20;
    if (items_sent < 2 * ITEM_TARGET / 3) return 80;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (items_sent < ITEM_TARGET / 3) return 80;
    if (items_sent < 2 * ITEM_TARGET / 3) return 20;
    return 0;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: sample pre-edge values, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      out_word.command      = cmd_t'(out_command);
      out_word.bus_byte     = out_bus_byte;
      out_word.recv_valid   = out_recv_valid;
      out_word.recv_byte    = out_recv_byte;
      out_word.done_res     = out_done_res;
      out_word.failed       = out_failed;
      out_word.error_status = out_error_status;
      board.check_command(out_word);
    end
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
  end

  task automatic write_regs(input logic [7:0] addr, input logic [7:0] scnt,
                            input logic [7:0] rcnt);
    reg_idx_t   idx [3];
    logic [7:0] val [3];
    idx = '{REG_SLAVE_ADDRESS, REG_SEND_COUNT, REG_RECEIVE_COUNT};
    val = '{addr, scnt, rcnt};
    cfg_valid <= 1'b1;
    foreach (idx[i]) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      board.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drives one bus event word and returns the command predicted for it.
  // Each cycle before the word goes out is idle with the stage's percentage.
  task automatic send_event(input logic [3:0] op, input logic [7:0] status,
                            input logic [7:0] tx, input logic [7:0] rx,
                            output res_t want);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_status_code <= status;
    in_tx_byte     <= tx;
    in_rx_byte     <= rx;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = board.predict_next_command(op, status, tx, rx);
    items_sent++;
  endtask

  task automatic send_rand(input logic [3:0] op, output res_t want);
    send_event(op, 8'($urandom), 8'($urandom), 8'($urandom), want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending_cmds.size() != 0);
  endtask

  // Answers each predicted command with the bus event a well-behaved slave
  // would cause, with an occasional random status thrown in when noisy.
  task automatic run_transaction(input bit noisy);
    res_t       want;
    logic [3:0] last_op;
    logic [3:0] op;
    bit         more;
    last_op = OP_BEGIN;
    more    = 1'b1;
    send_rand(OP_BEGIN, want);
    while (more) begin
      if (noisy && $urandom_range(0, 99) < 4) begin
        op = 4'($urandom_range(0, 15));
      end else begin
        case (want.command)
          CMD_START: op = (last_op == OP_BEGIN) ? OP_START : OP_RSTART;
          CMD_SEND: begin
            if (last_op == OP_START)       op = OP_ADDRW_ACK;
            else if (last_op == OP_RSTART) op = OP_ADDRR_ACK;
            else                           op = OP_DATA_ACK;
          end
          CMD_RX_ACK:  op = OP_RX_ACK;
          CMD_RX_NACK: op = OP_RX_NACK;
          default:     more = 1'b0;
        endcase
      end
      if (more) begin
        send_rand(op, want);
        last_op = op;
      end
    end
  endtask

  initial begin
    res_t want;
    bit   big_done;
    big_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: events while idle, read counter stuck at zero.
    send_event(OP_RX_ACK, 8'h00, 8'h00, 8'hFF, want);
    send_event(OP_OTHER, 8'hFF, 8'hFF, 8'h00, want);
    send_event(OP_BEGIN, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_START, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_ADDRR_ACK, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_RX_ACK, 8'h00, 8'h00, 8'hA5, want);
    send_event(OP_ADDRW_ACK, 8'h00, 8'hFF, 8'h00, want);
    drain();

    // Top address bit written too, so the address mask is exercised.
    write_regs(8'hFF, 8'd1, 8'd2);
    send_event(OP_BEGIN, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_START, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_ADDRW_ACK, 8'h00, 8'hFF, 8'h00, want);
    send_event(OP_DATA_ACK, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_RSTART, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_ADDRR_ACK, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_RX_ACK, 8'h00, 8'h00, 8'hFF, want);
    send_event(OP_RX_NACK, 8'hFF, 8'hFF, 8'h00, want);
    // Restart in the middle of a transfer, then unhandled statuses.
    send_event(OP_BEGIN, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_ADDRW_ACK, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_BEGIN, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_UNKNOWN_LAST, 8'hFF, 8'h00, 8'h00, want);
    send_event(OP_OTHER, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_BEGIN, 8'h00, 8'h00, 8'h00, want);
    send_event(OP_UNKNOWN_MID, 8'h5A, 8'h00, 8'h00, want);

    while (items_sent < ITEM_TARGET) begin
      drain();
      if (!big_done && items_sent > 500) begin
        // One transfer at the largest counts, left undisturbed.
        write_regs(8'h7F, 8'd255, 8'd255);
        run_transaction(1'b0);
        big_done = 1'b1;
      end else begin
        if ($urandom_range(0, 5) == 0)
          write_regs(8'($urandom), 8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)));
        else
          write_regs(8'($urandom), 8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)));
        repeat ($urandom_range(2, 5)) begin
          if ($urandom_range(0, 9) == 0) send_rand(4'($urandom_range(0, 15)), want);
          run_transaction(1'b1);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Drove %0d bus events over %0d ended transfers, including full-size counts.",
             items_sent, board.transfers_ended);
    $display("Checked %0d command words; %0d mismatches.",
             board.results_seen, board.mismatches);
    if (board.mismatches == 0 && board.pending_cmds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/i2cwr_pkg.sv
rtl/i2cwr_core.sv
rtl/i2cwr_out_skid.sv
rtl/i2c_master_write_read_sequencer.sv
verif/tb_i2c_master_write_read_sequencer.sv
